// ----- src/dbs_pkg.sv -----
`timescale 1ns / 1ps

package dbs_pkg;

    localparam int PAYLOAD_BYTES = 11;
    localparam int IDX_W         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [3:0] SEND_START = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_CMD_A  = 3'd0,
        REG_MODE_CMD_B  = 3'd1,
        REG_WRITE_CMD   = 3'd2,
        REG_READ_CMD    = 3'd3,
        REG_BUTTON_CODE = 3'd4
    } cfg_reg_t;

    localparam logic [2:0] ERR_PARTIAL  = 3'b001;
    localparam logic [2:0] ERR_SHORT    = 3'b010;
    localparam logic [2:0] ERR_OVERFLOW = 3'b100;

    typedef struct packed {
        logic       frame;
        logic       drive_enable;
        logic       drive_value;
        logic [7:0] brightness;
        logic [2:0] errors;
    } step_info_t;

endpackage

// ----- src/dbs_in_if.sv -----
`timescale 1ns / 1ps

interface dbs_in_if;
    logic valid;
    logic ready;
    logic from_clock_edge;
    logic select_level;
    logic clock_level;
    logic data_level;

    modport source (
        output valid, from_clock_edge, select_level, clock_level, data_level,
        input  ready
    );
    modport sink (
        input  valid, from_clock_edge, select_level, clock_level, data_level,
        output ready
    );
endinterface

// ----- src/dbs_out_if.sv -----
`timescale 1ns / 1ps

interface dbs_out_if;
    logic       valid;
    logic       ready;
    logic       is_payload;
    logic       drive_enable;
    logic       drive_value;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic [7:0] brightness_value;
    logic [2:0] error_flags;
    logic       last_item;

    modport source (
        output valid, is_payload, drive_enable, drive_value, byte_index,
               byte_value, brightness_value, error_flags, last_item,
        input  ready
    );
    modport sink (
        input  valid, is_payload, drive_enable, drive_value, byte_index,
               byte_value, brightness_value, error_flags, last_item,
        output ready
    );
endinterface

// ----- src/dbs_decoder.sv -----
`timescale 1ns / 1ps

module dbs_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                from_clock_edge,
    input  logic                                select_level,
    input  logic                                clock_level,
    input  logic                                data_level,
    input  logic                                cfg_we,
    input  logic [dbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dbs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [dbs_pkg::IDX_W-1:0]           rd_idx,
    output logic [7:0]                          rd_data,
    output dbs_pkg::step_info_t                 info
);

    logic [7:0]  mode_a_reg, mode_b_reg, write_cmd_reg, read_cmd_reg;
    logic [15:0] button_reg;

    logic        active_reg, active_next;
    logic        out_mode_reg, out_mode_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [3:0]  byte_cnt_reg, byte_cnt_next;
    logic [1:0]  stage_reg, stage_next;
    logic [3:0]  send_idx_reg, send_idx_next;
    logic [2:0]  errors_reg, errors_next;
    logic        drive_reg, drive_next;
    logic        store_we;
    logic [7:0]  store_reg [dbs_pkg::PAYLOAD_BYTES];

    logic        frame;
    logic [7:0]  bright;
    logic        do_end;
    logic        do_clock;

    assign rd_data = store_reg[rd_idx];

    always_comb
    begin
        active_next   = active_reg;
        out_mode_next = out_mode_reg;
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        stage_next    = stage_reg;
        send_idx_next = send_idx_reg;
        errors_next   = errors_reg;
        drive_next    = drive_reg;
        store_we      = 1'b0;
        frame         = 1'b0;
        bright        = 8'd0;
        do_end        = 1'b0;
        do_clock      = 1'b0;

        if (!from_clock_edge) begin
            if (select_level) begin
                do_end = 1'b1;
            end else begin
                active_next = 1'b1;
            end
        end else if (select_level && active_reg) begin
            do_end = 1'b1;
        end else begin
            if (!select_level) begin
                active_next = 1'b1;
            end
            do_clock = active_next;
        end

        // end of packet: count checks and command matching
        if (do_end) begin
            active_next   = 1'b0;
            out_mode_next = 1'b0;
            if (byte_cnt_reg != 4'(dbs_pkg::PAYLOAD_BYTES) && byte_cnt_reg != 4'd0) begin
                errors_next = errors_next | dbs_pkg::ERR_SHORT;
            end
            if (bit_cnt_reg != 3'd0) begin
                errors_next = errors_next | dbs_pkg::ERR_PARTIAL;
            end
            byte_cnt_next = 4'd0;
            bit_cnt_next  = 3'd0;
            if (shift_reg == mode_a_reg || shift_reg == mode_b_reg) begin
                stage_next = 2'd1;
            end else if (shift_reg == write_cmd_reg) begin
                stage_next = (stage_reg == 2'd1) ? 2'd2 : 2'd0;
            end else if (stage_reg == 2'd3) begin
                bright     = shift_reg;
                stage_next = 2'd0;
                frame      = 1'b1;
            end else if (stage_reg == 2'd2) begin
                stage_next = 2'd3;
            end
        end

        // one bus clock edge: drive a key bit or shift a data bit in
        if (do_clock) begin
            if (!clock_level && out_mode_reg) begin
                drive_next    = button_reg[send_idx_reg];
                send_idx_next = send_idx_reg + 4'd1;
            end
            if (clock_level && !out_mode_reg) begin
                shift_next   = {data_level, shift_reg[7:1]};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7) begin
                    if (stage_reg == 2'd2) begin
                        if (byte_cnt_reg < 4'(dbs_pkg::PAYLOAD_BYTES)) begin
                            store_we      = 1'b1;
                            byte_cnt_next = byte_cnt_reg + 4'd1;
                        end else begin
                            errors_next = errors_next | dbs_pkg::ERR_OVERFLOW;
                        end
                    end else if (shift_next == read_cmd_reg) begin
                        send_idx_next = dbs_pkg::SEND_START;
                        out_mode_next = 1'b1;
                    end
                end
            end
        end

        info.frame        = frame;
        info.drive_enable = out_mode_next;
        info.drive_value  = drive_next;
        info.brightness   = bright;
        info.errors       = errors_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_a_reg    <= 8'd0;
            mode_b_reg    <= 8'd0;
            write_cmd_reg <= 8'd0;
            read_cmd_reg  <= 8'd0;
            button_reg    <= 16'd0;
            active_reg    <= 1'b0;
            out_mode_reg  <= 1'b0;
            shift_reg     <= 8'd0;
            bit_cnt_reg   <= 3'd0;
            byte_cnt_reg  <= 4'd0;
            stage_reg     <= 2'd0;
            send_idx_reg  <= dbs_pkg::SEND_START;
            errors_reg    <= 3'd0;
            drive_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    dbs_pkg::REG_MODE_CMD_A:  mode_a_reg    <= cfg_data[7:0];
                    dbs_pkg::REG_MODE_CMD_B:  mode_b_reg    <= cfg_data[7:0];
                    dbs_pkg::REG_WRITE_CMD:   write_cmd_reg <= cfg_data[7:0];
                    dbs_pkg::REG_READ_CMD:    read_cmd_reg  <= cfg_data[7:0];
                    dbs_pkg::REG_BUTTON_CODE: button_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (step) begin
                active_reg   <= active_next;
                out_mode_reg <= out_mode_next;
                shift_reg    <= shift_next;
                bit_cnt_reg  <= bit_cnt_next;
                byte_cnt_reg <= byte_cnt_next;
                stage_reg    <= stage_next;
                send_idx_reg <= send_idx_next;
                errors_reg   <= frame ? 3'd0 : errors_next;
                drive_reg    <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && store_we) begin
            store_reg[byte_cnt_reg] <= shift_next;
        end
    end

endmodule

// ----- src/dbs_emitter.sv -----
`timescale 1ns / 1ps

module dbs_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  dbs_pkg::step_info_t           info,
    output logic                          busy,
    output logic [dbs_pkg::IDX_W-1:0]     rd_idx,
    input  logic [7:0]                    rd_data,
    dbs_out_if.source                     out_ch
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRIVE,
        S_PAYLOAD
    } state_t;

    localparam logic [dbs_pkg::IDX_W-1:0] LAST_IDX =
        dbs_pkg::IDX_W'(dbs_pkg::PAYLOAD_BYTES - 1);

    state_t                      state_reg;
    logic                        frame_reg;
    logic [dbs_pkg::IDX_W-1:0]   idx_reg;
    logic                        valid_reg;
    logic                        is_payload_reg;
    logic                        drive_en_reg;
    logic                        drive_val_reg;
    logic [3:0]                  byte_index_reg;
    logic [7:0]                  byte_value_reg;
    logic [7:0]                  bright_reg;
    logic [2:0]                  errors_reg;
    logic [7:0]                  hold_bright_reg;
    logic [2:0]                  hold_errors_reg;
    logic                        last_reg;

    assign busy   = (state_reg != S_IDLE);
    assign rd_idx = idx_reg;

    assign out_ch.valid            = valid_reg;
    assign out_ch.is_payload       = is_payload_reg;
    assign out_ch.drive_enable     = drive_en_reg;
    assign out_ch.drive_value      = drive_val_reg;
    assign out_ch.byte_index       = byte_index_reg;
    assign out_ch.byte_value       = byte_value_reg;
    assign out_ch.brightness_value = bright_reg;
    assign out_ch.error_flags      = errors_reg;
    assign out_ch.last_item        = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            frame_reg       <= 1'b0;
            idx_reg         <= '0;
            valid_reg       <= 1'b0;
            is_payload_reg  <= 1'b0;
            drive_en_reg    <= 1'b0;
            drive_val_reg   <= 1'b0;
            byte_index_reg  <= 4'd0;
            byte_value_reg  <= 8'd0;
            bright_reg      <= 8'd0;
            errors_reg      <= 3'd0;
            hold_bright_reg <= 8'd0;
            hold_errors_reg <= 3'd0;
            last_reg        <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        valid_reg       <= 1'b1;
                        is_payload_reg  <= 1'b0;
                        drive_en_reg    <= info.drive_enable;
                        drive_val_reg   <= info.drive_value;
                        byte_index_reg  <= 4'd0;
                        byte_value_reg  <= 8'd0;
                        bright_reg      <= 8'd0;
                        errors_reg      <= 3'd0;
                        last_reg        <= !info.frame;
                        frame_reg       <= info.frame;
                        hold_bright_reg <= info.brightness;
                        hold_errors_reg <= info.errors;
                        idx_reg         <= '0;
                        state_reg       <= S_DRIVE;
                    end
                end
                S_DRIVE, S_PAYLOAD:
                begin
                    if (out_ch.ready) begin
                        if (last_reg || (state_reg == S_DRIVE && !frame_reg)) begin
                            valid_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end else begin
                            // next payload byte of the completed frame
                            is_payload_reg <= 1'b1;
                            drive_en_reg   <= 1'b0;
                            drive_val_reg  <= 1'b0;
                            byte_index_reg <= 4'(idx_reg);
                            byte_value_reg <= rd_data;
                            bright_reg     <= hold_bright_reg;
                            errors_reg     <= hold_errors_reg;
                            last_reg       <= (idx_reg == LAST_IDX);
                            idx_reg        <= idx_reg + 1'b1;
                            state_reg      <= S_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- src/display_bus_sniffer.sv -----
`timescale 1ns / 1ps

// display_bus_sniffer
// in_ch carries one pin-change request of a three-wire display bus: which
// pin changed and the present select, clock and data levels.
// out_ch returns the results of each request in order: first a pin drive
// update (drive enable and level), then, when a frame completes, one
// result per payload byte with brightness and error flags. last_item marks
// the final result of a request.
// cfg_we / cfg_index / cfg_data write the command bytes and the key code;
// write them only while no request is in flight.
// latency: a request is decoded in the cycle it is accepted and its first
// result is valid on the next cycle.
// throughput: the output sequencer emits one result per cycle while
// out_ch.ready is high; a request yields a drive update only, or a drive
// update and then 11 payload results for a frame; in_ch.ready stays low
// until the last result of a request is taken. a stalled receiver holds the
// current result in the output register and keeps in_ch.ready low.
// reset clears the decoder, sticky errors and output valid; the payload
// store is not cleared.

module display_bus_sniffer (
    input  logic                               clk,
    input  logic                               rst_n,
    dbs_in_if.sink                             in_ch,
    dbs_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [dbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                         busy;
    logic                         step;
    logic [dbs_pkg::IDX_W-1:0]    rd_idx;
    logic [7:0]                   rd_data;
    dbs_pkg::step_info_t          info;

    assign in_ch.ready = !busy;
    assign step        = in_ch.valid && !busy;

    dbs_decoder u_decoder (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .from_clock_edge (in_ch.from_clock_edge),
        .select_level    (in_ch.select_level),
        .clock_level     (in_ch.clock_level),
        .data_level      (in_ch.data_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rd_idx          (rd_idx),
        .rd_data         (rd_data),
        .info            (info)
    );

    dbs_emitter u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (step),
        .info    (info),
        .busy    (busy),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .out_ch  (out_ch)
    );

endmodule
